// ===== hdl/asd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg
// Shared constants and types of the accelerometer step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

   // window of past magnitudes
   localparam int WINDOW_LEN = 10;
   localparam int SLOT_W     = $clog2(WINDOW_LEN);

   // field widths
   localparam int AXIS_W     = 16;
   localparam int MAG_W      = 16;
   localparam int MAG_MAX    = 56755;
   localparam int SQ_W       = 32;
   localparam int LEVEL_W    = 18;
   localparam int COUNT_W    = 32;
   localparam int ALPHA_W    = 9;
   localparam int HYST_W     = 16;
   localparam int SUM_W      = $clog2(WINDOW_LEN * MAG_MAX + 1);

   // mean by reciprocal multiply, one correction step afterwards
   localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'((64'd1 << RECIP_SHIFT) / WINDOW_LEN);

   // filter arithmetic
   localparam int ACC_W  = 28;
   localparam int FILT_W = ACC_W - 8;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd154;
   localparam logic [HYST_W-1:0]  HYST_RESET  = 16'd410;

   // sequencing
   localparam int AXES       = 3;
   localparam int ROOT_STEPS = 16;
   localparam int CNT_W      = 4;

   // register file
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_ALPHA = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS   = 4'd1;

   // stream payloads
   localparam int REQ_W = 48;
   localparam int RSP_W = 56;

   typedef struct packed {
      logic             load;
      logic             square;
      logic             root;
      logic             window;
      logic             mul;
      logic             div;
      logic             ewma_a;
      logic             ewma_b;
      logic             finish;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

endpackage : asd_pkg
`default_nettype wire

// ===== hdl/accel_step_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a new sample is accepted only in idle, once the previous one has been
//    written to the result register; each sample runs the 16-step square root
//    plus the squaring of the three axes and the mean and filter stages
// the result register lets the next sample start while a result waits
// reset: synchronous, clears the window, filter state, step count, led and
//    loads filter_alpha 154 and hysteresis 410; no clearing pass needed
// ----------------------------------------------------------------------------
// accel_step_detector
// Pedometer: magnitude of a three-axis sample, window mean removal, EWMA
// filter and zero crossing with hysteresis; one result beat per sample.
// ----------------------------------------------------------------------------
module accel_step_detector (
   input  wire                             clock,
   input  wire                             reset,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  wire [asd_pkg::REQ_W-1:0]        req_tdata,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // filtered_level [17:0], step_seen [18], steps_total [50:19],
   // led_on [51], zero [55:52]
   output logic [asd_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [asd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [asd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import asd_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   asd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   asd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule : accel_step_detector
`default_nettype wire

// ===== hdl/asd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_ctrl
// Sequencer of the step detector: steps the datapath through squaring,
// square root, window update, mean, filter and result, and owns rsp valid.
// ----------------------------------------------------------------------------
module asd_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output asd_pkg::cmd_type  cmd
);
   import asd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_WINDOW,
      ST_MUL,
      ST_DIV,
      ST_EWMA_A,
      ST_EWMA_B,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.cnt    = cnt_ff;
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.square = (state_ff == ST_SQUARE);
      cmd.root   = (state_ff == ST_ROOT);
      cmd.window = (state_ff == ST_WINDOW);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.div    = (state_ff == ST_DIV);
      cmd.ewma_a = (state_ff == ST_EWMA_A);
      cmd.ewma_b = (state_ff == ST_EWMA_B);
      cmd.finish = (state_ff == ST_FINISH) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (cnt_ff == CNT_W'(AXES - 1)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_WINDOW;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WINDOW: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    state_in = ST_EWMA_A;
         ST_EWMA_A: state_in = ST_EWMA_B;
         ST_EWMA_B: state_in = ST_FINISH;
         ST_FINISH: begin
            // hold here until the output register can take the result
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in work");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over one not yet taken");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("rsp valid raised without a finished item");

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> (cnt_ff < CNT_W'(AXES)))
      else $error("axis counter out of range");

endmodule : asd_ctrl
`default_nettype wire

// ===== hdl/asd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_datapath
// Magnitude, window mean, EWMA filter and step detection; holds the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module asd_datapath (
   input  wire                             clock,
   input  wire                             reset,
   input  asd_pkg::cmd_type                cmd,
   input  wire [asd_pkg::REQ_W-1:0]        req_tdata,
   input  wire                             csr_valid,
   input  wire [asd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [asd_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [asd_pkg::RSP_W-1:0]       rsp_tdata
);
   import asd_pkg::*;

   // configuration
   logic [ALPHA_W-1:0] alpha_ff;
   logic [HYST_W-1:0]  hyst_ff;

   // item registers
   logic signed [AXIS_W-1:0] axis_ff [AXES];
   logic [SQ_W-1:0]          rem_ff;
   logic [SQ_W-1:0]          res_ff;
   logic [MAG_W-1:0]         old_ff;
   logic                     old_vld_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [LEVEL_W-1:0] diff_ff;
   logic signed [ACC_W-1:0]  p1_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // running state
   logic [MAG_W-1:0]          window_mem [WINDOW_LEN];
   logic [WINDOW_LEN-1:0]     window_vld_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic signed [LEVEL_W-1:0] prev_ff;
   logic                      above_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      led_ff;

   // result register
   logic signed [LEVEL_W-1:0] out_level_ff;
   logic                      out_step_ff;
   logic [COUNT_W-1:0]        out_count_ff;
   logic                      out_led_ff;

   // combinational terms
   logic signed [AXIS_W-1:0] axis_sel;
   logic [AXIS_W-1:0]        axis_abs;
   logic [SQ_W-1:0]          axis_sq;
   logic [SQ_W-1:0]          root_bit;
   logic [SQ_W:0]            root_try;
   logic                     root_take;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W-1:0]         old_mag;
   logic [SUM_W-1:0]         q_est;
   logic [SUM_W-1:0]         rem_est;
   logic [SUM_W-1:0]         mean;
   logic [ALPHA_W-1:0]       alpha_eff;
   logic signed [ACC_W-1:0]  p2;
   logic signed [FILT_W-1:0] filt_wide;
   logic signed [LEVEL_W-1:0] filt;
   logic signed [LEVEL_W:0]  hyst_pos;
   logic signed [LEVEL_W:0]  hyst_neg;
   logic signed [LEVEL_W:0]  filt_ext;
   logic                     over_band;
   logic                     under_band;
   logic                     step;
   logic [COUNT_W-1:0]       count_next;

   // squaring, one axis a beat of the counter
   always_comb begin
      axis_sel = axis_ff[0];
      case (cmd.cnt[1:0])
         2'd0:    axis_sel = axis_ff[0];
         2'd1:    axis_sel = axis_ff[1];
         2'd2:    axis_sel = axis_ff[2];
         default: axis_sel = axis_ff[0];
      endcase
   end
   assign axis_abs = axis_sel[AXIS_W-1] ? (~axis_sel + 1'b1) : axis_sel;
   assign axis_sq  = axis_abs * axis_abs;

   // bitwise square root, one result bit per step
   assign root_bit  = 32'h4000_0000 >> {cmd.cnt, 1'b0};
   assign root_try  = {1'b0, res_ff} + {1'b0, root_bit};
   assign root_take = ({1'b0, rem_ff} >= root_try);
   assign mag       = res_ff[MAG_W-1:0];
   assign old_mag   = old_vld_ff ? old_ff : '0;

   // mean: estimate is the true quotient or one below it
   assign q_est   = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign rem_est = sum_ff - q_est * SUM_W'(WINDOW_LEN);
   assign mean    = (rem_est >= SUM_W'(WINDOW_LEN)) ? q_est + 1'b1 : q_est;

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign p2 = ACC_W'($signed({1'b0, ALPHA_ONE - alpha_eff}) * prev_ff);

   // arithmetic shift floors; saturate to the level range
   assign filt_wide = FILT_W'(acc_ff >>> 8);
   always_comb begin
      if (filt_wide > FILT_W'(2 ** (LEVEL_W - 1) - 1)) begin
         filt = {1'b0, {(LEVEL_W - 1){1'b1}}};
      end else if (filt_wide < -FILT_W'(2 ** (LEVEL_W - 1))) begin
         filt = {1'b1, {(LEVEL_W - 1){1'b0}}};
      end else begin
         filt = filt_wide[LEVEL_W-1:0];
      end
   end

   assign filt_ext   = {filt[LEVEL_W-1], filt};
   assign hyst_pos   = $signed({{(LEVEL_W + 1 - HYST_W){1'b0}}, hyst_ff});
   assign hyst_neg   = -hyst_pos;
   assign over_band  = filt_ext > hyst_pos;
   assign under_band = filt_ext < hyst_neg;
   assign step       = over_band && !above_ff;
   assign count_next = count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         hyst_ff  <= HYST_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_FILTER_ALPHA) begin
            alpha_ff <= csr_data[ALPHA_W-1:0];
         end else if (csr_index == REG_HYSTERESIS) begin
            hyst_ff <= csr_data[HYST_W-1:0];
         end
      end
   end

   // window store, read registered at the current slot
   always_ff @(posedge clock) begin
      old_ff <= window_mem[slot_ff];
      if (cmd.window) begin
         window_mem[slot_ff] <= mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_vld_ff <= '0;
         old_vld_ff    <= 1'b0;
         slot_ff       <= '0;
         sum_ff        <= '0;
         prev_ff       <= '0;
         above_ff      <= 1'b0;
         count_ff      <= '0;
         led_ff        <= 1'b0;
      end else begin
         old_vld_ff <= window_vld_ff[slot_ff];
         if (cmd.window) begin
            window_vld_ff[slot_ff] <= 1'b1;
            sum_ff <= sum_ff - SUM_W'(old_mag) + SUM_W'(mag);
            slot_ff <= (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
         end
         if (cmd.finish) begin
            prev_ff <= filt;
            if (over_band) begin
               above_ff <= 1'b1;
               if (step) begin
                  count_ff <= count_next;
                  led_ff   <= !count_next[0];
               end
            end else if (under_band) begin
               above_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff[0] <= req_tdata[AXIS_W-1:0];
         axis_ff[1] <= req_tdata[2*AXIS_W-1:AXIS_W];
         axis_ff[2] <= req_tdata[3*AXIS_W-1:2*AXIS_W];
      end
      if (cmd.square) begin
         rem_ff <= ((cmd.cnt == '0) ? '0 : rem_ff) + axis_sq;
         res_ff <= '0;
      end
      if (cmd.root) begin
         if (root_take) begin
            rem_ff <= rem_ff - root_try[SQ_W-1:0];
            res_ff <= (res_ff >> 1) + root_bit;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP_MUL);
      end
      if (cmd.div) begin
         diff_ff <= $signed({2'b00, mag}) - $signed({2'b00, mean[MAG_W-1:0]});
      end
      if (cmd.ewma_a) begin
         p1_ff <= ACC_W'($signed({1'b0, alpha_eff}) * diff_ff);
      end
      if (cmd.ewma_b) begin
         acc_ff <= p1_ff + p2 + ACC_W'(128);
      end
      if (cmd.finish) begin
         out_level_ff <= filt;
         out_step_ff  <= step;
         out_count_ff <= step ? count_next : count_ff;
         out_led_ff   <= step ? !count_next[0] : led_ff;
      end
   end

   assign rsp_tdata = {4'b0000, out_led_ff, out_count_ff, out_step_ff, out_level_ff};

endmodule : asd_datapath
`default_nettype wire
